>>> src/sist_pkg.sv
// Package for the sorted interval set table.
// Holds operation codes, controller states and the controller/datapath link types.
package sist_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int POS_WIDTH_DEF   = 32;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;
  localparam logic [1:0] KIND_RANGE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROC,
    ST_SECOND,
    ST_FIN,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;   // latch the item and clear the scan state
    logic rd;      // read the next stored entry
    logic proc;    // handle the entry just read
    logic proc2;   // write the second piece of that entry
    logic fin;     // write the trailing pending range
    logic commit;  // switch banks if allowed and load the result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan;      // item needs a pass over the table
    logic more;      // entries remain to be read
    logic need2;     // current entry emits two pieces
    logic out_busy;  // result register still holds an untaken item
  } sts_t;

endpackage

>>> src/sorted_interval_set_table_top.sv
// Top level of the sorted interval set table: the controller and the datapath.
// Depends on sist_pkg, sist_ctrl and sist_dp.
//
// Usage: one input channel (in_valid/in_ready, fields kind, range_start,
// range_end) and one result channel (out_valid/out_ready, fields status,
// found, result_start, result_end). Every item yields exactly one result.
// Kinds: insert merges a range, remove cuts it out, cover point returns the
// entry holding a point, cover range the hull of range and touched entries.
// An item that scans the table reads and handles each stored entry in turn,
// with an extra step when an entry is written as two pieces (at most once
// per item). Insert, remove and cover range items with an empty range skip
// the scan.
// One item is handled at a time; a new item is taken as soon as the previous
// result sits in the output register, even if it has not been taken yet.
// If the receiver stalls, the block finishes the next item and then waits
// until the held result is taken. Reset empties the table at once.
module sorted_interval_set_table_top #(
  parameter int TABLE_DEPTH = sist_pkg::TABLE_DEPTH_DEF,
  parameter int POS_WIDTH   = sist_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [POS_WIDTH-1:0] range_start,
  input  logic [POS_WIDTH-1:0] range_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic                 found,
  output logic [POS_WIDTH-1:0] result_start,
  output logic [POS_WIDTH-1:0] result_end
);

  sist_pkg::cmd_t cmd;
  sist_pkg::sts_t sts;

  sist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sist_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POS_WIDTH   (POS_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .range_start  (range_start),
    .range_end    (range_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found        (found),
    .result_start (result_start),
    .result_end   (result_end)
  );

endmodule

>>> src/sist_ctrl.sv
// Controller state machine of the sorted interval set table.
// Uses sist_pkg for the state type and the command and status structs.
module sist_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sist_pkg::sts_t  sts,
  output sist_pkg::cmd_t  cmd
);

  sist_pkg::state_t state, state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sist_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the pass over the table
  always_comb begin
    state_next = state;
    unique case (state)
      sist_pkg::ST_IDLE: begin
        if (in_valid) state_next = sist_pkg::ST_CHECK;
      end
      sist_pkg::ST_CHECK: begin
        if (!sts.scan) state_next = sist_pkg::ST_DONE;
        else if (sts.more) state_next = sist_pkg::ST_PROC;
        else state_next = sist_pkg::ST_FIN;
      end
      sist_pkg::ST_PROC: begin
        if (sts.need2) state_next = sist_pkg::ST_SECOND;
        else state_next = sist_pkg::ST_CHECK;
      end
      sist_pkg::ST_SECOND: state_next = sist_pkg::ST_CHECK;
      sist_pkg::ST_FIN:    state_next = sist_pkg::ST_DONE;
      sist_pkg::ST_DONE: begin
        if (!sts.out_busy) state_next = sist_pkg::ST_IDLE;
      end
      default: state_next = sist_pkg::ST_IDLE;
    endcase
  end

  // Drive commands per state
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      sist_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      sist_pkg::ST_CHECK:  cmd.rd    = sts.scan && sts.more;
      sist_pkg::ST_PROC:   cmd.proc  = 1'b1;
      sist_pkg::ST_SECOND: cmd.proc2 = 1'b1;
      sist_pkg::ST_FIN:    cmd.fin   = 1'b1;
      sist_pkg::ST_DONE:   cmd.commit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

>>> src/sist_dp.sv
// Datapath of the sorted interval set table: two-bank entry memory, scan logic
// and result register. Uses sist_pkg for operation codes and link structs.
module sist_dp #(
  parameter int TABLE_DEPTH = sist_pkg::TABLE_DEPTH_DEF,
  parameter int POS_WIDTH   = sist_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sist_pkg::cmd_t       cmd,
  output sist_pkg::sts_t       sts,
  input  logic [1:0]           kind,
  input  logic [POS_WIDTH-1:0] range_start,
  input  logic [POS_WIDTH-1:0] range_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic                 found,
  output logic [POS_WIDTH-1:0] result_start,
  output logic [POS_WIDTH-1:0] result_end
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 2);
  localparam int MD = 2 ** (IW + 1);

  // Entry memory, one bank live and one being rebuilt
  logic [POS_WIDTH-1:0] mem_s [MD];
  logic [POS_WIDTH-1:0] mem_e [MD];
  logic [POS_WIDTH-1:0] rd_a, rd_b;

  logic [1:0]           kind_q;
  logic [POS_WIDTH-1:0] s_q, e_q, ms, me, rs, re;
  logic                 bank, placed, ovf, hit, fnd;
  logic [CW-1:0]        count, rd_idx, wr_cnt;

  logic                 e1_v, need2, merge, fv, wv, w_ok, mod, scan;
  logic [POS_WIDTH-1:0] e1_s, e1_e, w_s, w_e;

  assign mod  = (kind_q == sist_pkg::KIND_INSERT || kind_q == sist_pkg::KIND_REMOVE)
                && (s_q < e_q);
  assign scan = mod || (kind_q == sist_pkg::KIND_POINT)
                || (kind_q == sist_pkg::KIND_RANGE && s_q < e_q);

  // Classify the entry just read
  always_comb begin
    e1_v  = 1'b0;
    e1_s  = rd_a;
    e1_e  = rd_b;
    need2 = 1'b0;
    merge = 1'b0;
    if (kind_q == sist_pkg::KIND_INSERT) begin
      if (rd_b < s_q) begin
        e1_v = 1'b1;
      end else if (rd_a <= e_q) begin
        merge = 1'b1;
      end else if (!placed) begin
        e1_v  = 1'b1;
        e1_s  = ms;
        e1_e  = me;
        need2 = 1'b1;
      end else begin
        e1_v = 1'b1;
      end
    end else if (kind_q == sist_pkg::KIND_REMOVE) begin
      if (rd_b <= s_q || rd_a >= e_q) begin
        e1_v = 1'b1;
      end else if (rd_a < s_q) begin
        e1_v  = 1'b1;
        e1_e  = s_q;
        need2 = (rd_b > e_q);
      end else if (rd_b > e_q) begin
        e1_v = 1'b1;
        e1_s = e_q;
      end
    end
  end

  // Select the piece to write into the spare bank
  assign fv = (kind_q == sist_pkg::KIND_INSERT) && !placed;
  always_comb begin
    wv  = 1'b0;
    w_s = e1_s;
    w_e = e1_e;
    priority if (cmd.proc) begin
      wv = e1_v;
    end else if (cmd.proc2) begin
      wv  = 1'b1;
      w_s = (kind_q == sist_pkg::KIND_INSERT) ? rd_a : e_q;
      w_e = rd_b;
    end else if (cmd.fin) begin
      wv  = fv;
      w_s = ms;
      w_e = me;
    end else begin
      wv = 1'b0;
    end
  end
  assign w_ok = wr_cnt < CW'(TABLE_DEPTH);
  assign hit  = (rd_a <= s_q) && (s_q < rd_b);

  // Memory read and write ports
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a <= mem_s[{bank, rd_idx[IW-1:0]}];
      rd_b <= mem_e[{bank, rd_idx[IW-1:0]}];
    end
    if (wv && w_ok) begin
      mem_s[{~bank, wr_cnt[IW-1:0]}] <= w_s;
      mem_e[{~bank, wr_cnt[IW-1:0]}] <= w_e;
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      placed <= 1'b0;
      ovf    <= 1'b0;
      rd_idx <= '0;
      wr_cnt <= '0;
      fnd    <= 1'b0;
    end else if (cmd.start) begin
      kind_q <= kind;
      s_q    <= range_start;
      e_q    <= range_end;
      ms     <= range_start;
      me     <= range_end;
      placed <= 1'b0;
      ovf    <= 1'b0;
      rd_idx <= '0;
      wr_cnt <= '0;
      fnd    <= 1'b0;
      if (kind == sist_pkg::KIND_RANGE && range_start < range_end) begin
        rs <= range_start;
        re <= range_end;
      end else begin
        rs <= '0;
        re <= '0;
      end
    end else begin
      if (cmd.rd) rd_idx <= rd_idx + CW'(1);
      if (wv) begin
        wr_cnt <= wr_cnt + CW'(1);
        if (!w_ok) ovf <= 1'b1;
      end
      if (cmd.proc) begin
        if (merge) begin
          if (rd_a < ms) ms <= rd_a;
          if (rd_b > me) me <= rd_b;
        end
        if (kind_q == sist_pkg::KIND_INSERT && need2) placed <= 1'b1;
        if (kind_q == sist_pkg::KIND_POINT && !fnd && hit) begin
          fnd <= 1'b1;
          rs  <= rd_a;
          re  <= rd_b;
        end
        if (kind_q == sist_pkg::KIND_RANGE && rd_b >= s_q && rd_a <= e_q) begin
          if (rd_a < rs) rs <= rd_a;
          if (rd_b > re) re <= rd_b;
        end
      end
      if (cmd.fin && fv) placed <= 1'b1;
    end
  end

  // Live bank and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
    end else if (cmd.commit && mod && !ovf) begin
      bank  <= ~bank;
      count <= wr_cnt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= mod && ovf;
      found        <= fnd;
      result_start <= rs;
      result_end   <= re;
    end
  end

  assign sts.scan     = scan;
  assign sts.more     = rd_idx < count;
  assign sts.need2    = need2;
  assign sts.out_busy = out_valid && !out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> rd_idx < count)
    else $error("read past the last entry");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    wr_cnt <= CW'(TABLE_DEPTH + 1))
    else $error("write count beyond one past depth");

endmodule
